// File: design/idba_pkg.sv
`timescale 1ns / 1ps
// Package for the identifier bitmap allocator.
// Holds command codes, field widths and the mark memory row geometry.
package idba_pkg;

  localparam int SLOT_COUNT_DEF = 128;

  localparam int KIND_W     = 3;
  localparam int SLOT_W     = 9;
  localparam int NEW_SLOT_W = 7;
  localparam int FOUND_W    = 8;

  localparam logic [KIND_W-1:0] KIND_ALLOCATE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SWITCH   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;

  // Marks per memory row and index width within a row.
  localparam int ROW_W = 32;
  localparam int BIT_W = 5;

  // Wide enough to compare any slot against any slot count.
  localparam int CMP_W = 11;

  localparam logic [FOUND_W-1:0] FOUND_NONE = 8'hFF;

endpackage

// File: design/idba_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module idba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/id_bitmap_allocator.sv
`timescale 1ns / 1ps
// Identifier bitmap allocator: top level, command sequencer and mark memory.
// Depends on idba_pkg and idba_ram.
//
// One used mark per slot, kept in a memory of 32-mark rows with a registered read.
// A command is taken when start is high and busy is low; its single result shows
// on found_slot and is_free for exactly one cycle with done high, and the
// receiver must take it then. Clear, undefined kinds, and release or switch with
// no slot in range answer in the cycle after the command, without raising busy.
// Query and release read one row; switch reads one row, or two when old and new
// slot lie in different rows (one memory read per row touched). Allocate scans
// one row per cycle from the start row up to the last row. Clear takes effect
// at once through per-row valid bits; there is no clearing pass after reset.
module id_bitmap_allocator #(
  parameter int SLOT_COUNT = idba_pkg::SLOT_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [idba_pkg::KIND_W-1:0]           kind,
  input  logic signed [idba_pkg::SLOT_W-1:0]    slot,
  input  logic [idba_pkg::NEW_SLOT_W-1:0]       new_slot,
  input  logic                                  take,
  output logic                                  done,
  output logic signed [idba_pkg::FOUND_W-1:0]   found_slot,
  output logic                                  is_free
);

  import idba_pkg::*;

  localparam int ROWS      = (SLOT_COUNT + ROW_W - 1) / ROW_W;
  localparam int ROW_AW    = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int LAST_BITS = SLOT_COUNT - (ROWS - 1) * ROW_W;
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);
  localparam logic [ROW_W-1:0]  LAST_MASK = ROW_W'((64'(1) << LAST_BITS) - 64'(1));
  localparam logic [CMP_W-1:0]  SLOT_LIMIT = CMP_W'(SLOT_COUNT);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ALLOC  = 3'd1;
  localparam logic [2:0] ST_QUERY  = 3'd2;
  localparam logic [2:0] ST_REL    = 3'd3;
  localparam logic [2:0] ST_SW_OLD = 3'd4;
  localparam logic [2:0] ST_SW_NEW = 3'd5;

  logic [2:0]          state, state_next;
  logic [ROW_AW-1:0]   cur_row, cur_row_next;
  logic [BIT_W-1:0]    bit_a, bit_a_next;
  logic [ROW_AW-1:0]   new_row, new_row_next;
  logic [BIT_W-1:0]    new_bit, new_bit_next;
  logic                take_r, take_r_next;
  logic                first, first_next;
  logic                new_ok_r, new_ok_r_next;
  logic                slot_ok_r, slot_ok_r_next;
  logic [ROWS-1:0]     row_valid, row_valid_next;
  logic                done_next;
  logic [FOUND_W-1:0]  found_next;
  logic                is_free_next;

  logic                accept;
  logic                slot_ok, new_ok;
  logic [CMP_W-1:0]    slot_ext, new_ext;
  logic [ROW_AW-1:0]   in_row, in_new_row;
  logic [BIT_W-1:0]    in_bit, in_new_bit;

  logic                ram_we;
  logic [ROW_AW-1:0]   ram_waddr, ram_raddr;
  logic [ROW_W-1:0]    ram_wdata, ram_rdata;
  logic [ROW_W-1:0]    row_data, free_bits;
  logic                hit;
  logic [BIT_W-1:0]    hit_bit;
  logic [CMP_W-1:0]    hit_idx;

  idba_ram #(
    .WIDTH(ROW_W),
    .DEPTH(ROWS)
  ) u_marks (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign slot_ext   = {3'b000, slot[7:0]};
  assign new_ext    = {4'b0000, new_slot};
  assign slot_ok    = !slot[SLOT_W-1] && (slot_ext < SLOT_LIMIT);
  assign new_ok     = (new_ext < SLOT_LIMIT);
  assign in_row     = ROW_AW'(slot_ext >> BIT_W);
  assign in_bit     = slot[BIT_W-1:0];
  assign in_new_row = ROW_AW'(new_ext >> BIT_W);
  assign in_new_bit = new_slot[BIT_W-1:0];

  assign row_data  = row_valid[cur_row] ? ram_rdata : '0;
  assign free_bits = ~row_data
                   & (first ? ({ROW_W{1'b1}} << bit_a) : {ROW_W{1'b1}})
                   & ((cur_row == LAST_ROW) ? LAST_MASK : {ROW_W{1'b1}});
  assign hit       = |free_bits;
  assign hit_idx   = (CMP_W'(cur_row) << BIT_W) | CMP_W'(hit_bit);

  always_comb begin
    hit_bit = '0;
    for (int k = ROW_W - 1; k >= 0; k--) begin
      if (free_bits[k]) begin
        hit_bit = BIT_W'(k);
      end
    end
  end

  always_comb begin
    state_next     = state;
    cur_row_next   = cur_row;
    bit_a_next     = bit_a;
    new_row_next   = new_row;
    new_bit_next   = new_bit;
    take_r_next    = take_r;
    first_next     = first;
    new_ok_r_next  = new_ok_r;
    slot_ok_r_next = slot_ok_r;
    row_valid_next = row_valid;
    done_next      = 1'b0;
    found_next     = found_slot;
    is_free_next   = is_free;
    ram_we         = 1'b0;
    ram_waddr      = cur_row;
    ram_wdata      = row_data;
    ram_raddr      = cur_row;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          found_next   = '0;
          is_free_next = 1'b0;
          unique case (kind)
            KIND_ALLOCATE: begin
              cur_row_next = slot_ok ? in_row : '0;
              bit_a_next   = slot_ok ? in_bit : '0;
              take_r_next  = take;
              first_next   = 1'b1;
              ram_raddr    = cur_row_next;
              state_next   = ST_ALLOC;
            end
            KIND_QUERY: begin
              cur_row_next   = slot_ok ? in_row : '0;
              bit_a_next     = in_bit;
              slot_ok_r_next = slot_ok;
              ram_raddr      = cur_row_next;
              state_next     = ST_QUERY;
            end
            KIND_SWITCH: begin
              new_row_next  = in_new_row;
              new_bit_next  = in_new_bit;
              new_ok_r_next = new_ok;
              if (slot_ok) begin
                cur_row_next = in_row;
                bit_a_next   = in_bit;
                ram_raddr    = in_row;
                state_next   = ST_SW_OLD;
              end else if (new_ok) begin
                cur_row_next = in_new_row;
                ram_raddr    = in_new_row;
                state_next   = ST_SW_NEW;
              end else begin
                done_next = 1'b1;
              end
            end
            KIND_RELEASE: begin
              if (slot_ok) begin
                cur_row_next = in_row;
                bit_a_next   = in_bit;
                ram_raddr    = in_row;
                state_next   = ST_REL;
              end else begin
                done_next = 1'b1;
              end
            end
            KIND_CLEAR: begin
              row_valid_next = '0;
              done_next      = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        if (hit) begin
          ram_we     = 1'b1;
          ram_wdata  = row_data;
          ram_wdata[hit_bit] = take_r;
          row_valid_next[cur_row] = 1'b1;
          found_next = FOUND_W'(hit_idx);
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (cur_row == LAST_ROW) begin
          found_next = FOUND_NONE;
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cur_row_next = cur_row + 1'b1;
          first_next   = 1'b0;
          ram_raddr    = cur_row_next;
        end
      end
      ST_QUERY: begin
        is_free_next = slot_ok_r && !row_data[bit_a];
        done_next    = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_REL: begin
        ram_we     = 1'b1;
        ram_wdata  = row_data & ~(ROW_W'(1) << bit_a);
        row_valid_next[cur_row] = 1'b1;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SW_OLD: begin
        ram_we    = 1'b1;
        ram_wdata = row_data & ~(ROW_W'(1) << bit_a);
        if (new_ok_r && (new_row == cur_row)) begin
          ram_wdata = ram_wdata | (ROW_W'(1) << new_bit);
        end
        row_valid_next[cur_row] = 1'b1;
        if (new_ok_r && (new_row != cur_row)) begin
          cur_row_next = new_row;
          ram_raddr    = new_row;
          state_next   = ST_SW_NEW;
        end else begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SW_NEW: begin
        ram_we     = 1'b1;
        ram_wdata  = row_data | (ROW_W'(1) << new_bit);
        row_valid_next[cur_row] = 1'b1;
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      row_valid <= row_valid_next;
      done      <= done_next;
    end
    cur_row    <= cur_row_next;
    bit_a      <= bit_a_next;
    new_row    <= new_row_next;
    new_bit    <= new_bit_next;
    take_r     <= take_r_next;
    first      <= first_next;
    new_ok_r   <= new_ok_r_next;
    slot_ok_r  <= slot_ok_r_next;
    found_slot <= found_next;
    is_free    <= is_free_next;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_ALLOC || state == ST_REL ||
                state == ST_SW_OLD || state == ST_SW_NEW))
    else $error("mark write outside a modify step");

  a_write_row: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ram_waddr <= LAST_ROW))
    else $error("mark write beyond last row");

  a_one_field: assert property (@(posedge clk) disable iff (rst)
    (done && is_free) |-> (found_slot == '0))
    else $error("query answer with nonzero slot");

  a_clear_fast: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_CLEAR) |=> (done && row_valid == '0))
    else $error("clear did not complete in one cycle");

endmodule
